// ===== rtl/core/quaternion_multiply_normalize_top_assert.svh =====
// Assertion macros for the quaternion multiply and normalize block.
// Included by the modules that carry concurrent assertions.
`ifndef QUATERNION_MULTIPLY_NORMALIZE_TOP_ASSERT_SVH
`define QUATERNION_MULTIPLY_NORMALIZE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define QMN_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("qmn assertion failed");
`define QMN_NEVER(lbl, clk_s, rstn_s, cond) \
  `QMN_ASSERT(lbl, clk_s, rstn_s, !(cond))
`else
`define QMN_ASSERT(lbl, clk_s, rstn_s, prop)
`define QMN_NEVER(lbl, clk_s, rstn_s, cond)
`endif
`endif

// ===== rtl/core/qmn_pkg.sv =====
// Shared constants and types of the quaternion multiply and normalize block.
// Used by every module in rtl/core.
package qmn_pkg;

  localparam int FRAC_BITS = 14;
  localparam int DW        = 16;
  localparam int IN_W      = 8 * DW;
  localparam int OUT_W     = 4 * DW;
  localparam int PW        = 2 * DW + 2;
  localparam int MW        = PW - 1;
  localparam int NAW       = 2 * DW + 1;
  localparam int PRW       = 2 * NAW;
  localparam int FLOORW    = 15;
  localparam int F2W       = 2 * FLOORW;
  localparam int SQW       = 30;
  localparam int SQ_MSB    = SQW - 1;
  localparam int RADW      = 2 * SQW + 2;
  localparam int STW       = RADW + 1;
  localparam int NSQRT     = RADW / 2;
  localparam int ROOTW     = NSQRT;
  localparam int REMW      = ROOTW + 1;
  localparam int QBITS     = FRAC_BITS + 1;
  localparam int NUMW      = SQW + QBITS;
  localparam logic [DW-1:0] ONE = DW'(1) << FRAC_BITS;

  typedef struct packed {
    logic [3:0][SQW-1:0] q;
    logic [3:0]          neg;
    logic                degen;
  } norm_t;

endpackage

// ===== rtl/core/qmn_product.sv =====
// Hamilton product and squared input norms, two register stages.
// Depends on qmn_pkg.
module qmn_product (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  v_in,
  input  logic [qmn_pkg::IN_W-1:0]              d_in,
  output logic                                  v_out,
  output logic [3:0][qmn_pkg::PW-1:0]           p_out,
  output logic [qmn_pkg::NAW-1:0]               na_out,
  output logic [qmn_pkg::NAW-1:0]               nb_out
);

  logic signed [qmn_pkg::DW-1:0]   a [4];
  logic signed [qmn_pkg::DW-1:0]   b [4];
  logic signed [2*qmn_pkg::DW-1:0] pr_r [16];
  logic signed [2*qmn_pkg::DW-1:0] sa_r [4];
  logic signed [2*qmn_pkg::DW-1:0] sb_r [4];
  logic [1:0]                      v_r;
  logic [3:0][qmn_pkg::PW-1:0]     p_r;
  logic [qmn_pkg::NAW-1:0]         na_r;
  logic [qmn_pkg::NAW-1:0]         nb_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      a[i] = signed'(d_in[qmn_pkg::DW*i +: qmn_pkg::DW]);
      b[i] = signed'(d_in[qmn_pkg::DW*(i+4) +: qmn_pkg::DW]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          pr_r[i*4+j] <= a[i] * b[j];
        end
        sa_r[i] <= a[i] * a[i];
        sb_r[i] <= b[i] * b[i];
      end
      p_r[0] <= qmn_pkg::PW'(pr_r[0]) - qmn_pkg::PW'(pr_r[5])
              - qmn_pkg::PW'(pr_r[10]) - qmn_pkg::PW'(pr_r[15]);
      p_r[1] <= qmn_pkg::PW'(pr_r[1]) + qmn_pkg::PW'(pr_r[4])
              + qmn_pkg::PW'(pr_r[11]) - qmn_pkg::PW'(pr_r[14]);
      p_r[2] <= qmn_pkg::PW'(pr_r[2]) - qmn_pkg::PW'(pr_r[7])
              + qmn_pkg::PW'(pr_r[8]) + qmn_pkg::PW'(pr_r[13]);
      p_r[3] <= qmn_pkg::PW'(pr_r[3]) + qmn_pkg::PW'(pr_r[6])
              - qmn_pkg::PW'(pr_r[9]) + qmn_pkg::PW'(pr_r[12]);
      na_r <= qmn_pkg::NAW'(sa_r[0][2*qmn_pkg::DW-2:0]) + qmn_pkg::NAW'(sa_r[1][2*qmn_pkg::DW-2:0])
            + qmn_pkg::NAW'(sa_r[2][2*qmn_pkg::DW-2:0]) + qmn_pkg::NAW'(sa_r[3][2*qmn_pkg::DW-2:0]);
      nb_r <= qmn_pkg::NAW'(sb_r[0][2*qmn_pkg::DW-2:0]) + qmn_pkg::NAW'(sb_r[1][2*qmn_pkg::DW-2:0])
            + qmn_pkg::NAW'(sb_r[2][2*qmn_pkg::DW-2:0]) + qmn_pkg::NAW'(sb_r[3][2*qmn_pkg::DW-2:0]);
    end
  end

  assign v_out  = v_r[1];
  assign p_out  = p_r;
  assign na_out = na_r;
  assign nb_out = nb_r;

endmodule

// ===== rtl/core/qmn_scale.sv =====
// Floor test, power-of-two scaling and sum of squares, five register stages.
// Depends on qmn_pkg.
module qmn_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          v_in,
  input  logic [3:0][qmn_pkg::PW-1:0]   p_in,
  input  logic [qmn_pkg::NAW-1:0]       na_in,
  input  logic [qmn_pkg::NAW-1:0]       nb_in,
  input  logic [qmn_pkg::F2W-1:0]       f2,
  output logic                          v_out,
  output logic [qmn_pkg::RADW-1:0]      sq_out,
  output qmn_pkg::norm_t                nm_out
);

  logic [4:0]                        v_r;
  logic [3:0][qmn_pkg::MW-1:0]       q3_r;
  logic [3:0]                        neg3_r;
  logic [qmn_pkg::MW-1:0]            m3_r;
  logic [qmn_pkg::PRW-1:0]           prod3_r;
  logic [3:0][qmn_pkg::MW-1:0]       q4_r;
  logic [3:0]                        neg4_r;
  logic                              degen4_r;
  logic [5:0]                        pos4_r;
  qmn_pkg::norm_t                    nm5_r;
  qmn_pkg::norm_t                    nm6_r;
  qmn_pkg::norm_t                    nm7_r;
  logic [3:0][2*qmn_pkg::SQW-1:0]    sqs6_r;
  logic [qmn_pkg::RADW-1:0]          sq7_r;
  logic [3:0][qmn_pkg::MW-1:0]       mag;
  logic [qmn_pkg::MW-1:0]            mx;
  logic [5:0]                        pos;
  logic [qmn_pkg::PRW-1:0]           thr;
  qmn_pkg::norm_t                    nm5_nxt;

  always_comb begin
    mx = '0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = p_in[i][qmn_pkg::PW-1] ? qmn_pkg::MW'(-p_in[i]) : qmn_pkg::MW'(p_in[i]);
      if (mag[i] > mx) begin
        mx = mag[i];
      end
    end
  end

  always_comb begin
    pos = '0;
    for (int k = 0; k < qmn_pkg::MW; k++) begin
      if (m3_r[k]) begin
        pos = 6'(k);
      end
    end
  end

  assign thr = qmn_pkg::PRW'(f2) << (2 * qmn_pkg::FRAC_BITS);

  always_comb begin
    nm5_nxt.neg   = neg4_r;
    nm5_nxt.degen = degen4_r;
    for (int i = 0; i < 4; i++) begin
      if (pos4_r >= 6'(qmn_pkg::SQ_MSB)) begin
        nm5_nxt.q[i] = qmn_pkg::SQW'(q4_r[i] >> (pos4_r - 6'(qmn_pkg::SQ_MSB)));
      end else begin
        nm5_nxt.q[i] = qmn_pkg::SQW'(q4_r[i] << (6'(qmn_pkg::SQ_MSB) - pos4_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        q3_r[i]   <= mag[i];
        neg3_r[i] <= p_in[i][qmn_pkg::PW-1];
        sqs6_r[i] <= nm5_r.q[i] * nm5_r.q[i];
      end
      m3_r     <= mx;
      prod3_r  <= na_in * nb_in;
      q4_r     <= q3_r;
      neg4_r   <= neg3_r;
      degen4_r <= prod3_r <= thr;
      pos4_r   <= pos;
      nm5_r    <= nm5_nxt;
      nm6_r    <= nm5_r;
      nm7_r    <= nm6_r;
      sq7_r    <= qmn_pkg::RADW'(sqs6_r[0]) + qmn_pkg::RADW'(sqs6_r[1])
                + qmn_pkg::RADW'(sqs6_r[2]) + qmn_pkg::RADW'(sqs6_r[3]);
    end
  end

  assign v_out  = v_r[4];
  assign sq_out = sq7_r;
  assign nm_out = nm7_r;

endmodule

// ===== rtl/core/qmn_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on qmn_pkg.
module qmn_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       v_in,
  input  logic [qmn_pkg::RADW-1:0]   sq_in,
  input  qmn_pkg::norm_t             nm_in,
  output logic                       v_out,
  output logic [qmn_pkg::ROOTW-1:0]  root_out,
  output qmn_pkg::norm_t             nm_out
);

  typedef struct packed {
    logic [qmn_pkg::STW-1:0] x;
    logic [qmn_pkg::STW-1:0] res;
  } sqst_t;

  localparam int NS = qmn_pkg::NSQRT;

  logic [NS-1:0]  v_r;
  sqst_t          st_r [NS];
  qmn_pkg::norm_t nm_r [NS];
  sqst_t          st_in;

  function automatic sqst_t sq_step(sqst_t s, logic [qmn_pkg::STW-1:0] bit_v);
    sqst_t o;
    o = s;
    if (s.x >= s.res + bit_v) begin
      o.x   = s.x - (s.res + bit_v);
      o.res = (s.res >> 1) + bit_v;
    end else begin
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  assign st_in.x   = qmn_pkg::STW'(sq_in);
  assign st_in.res = '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= sq_step(st_in, qmn_pkg::STW'(1) << (qmn_pkg::RADW - 2));
      nm_r[0] <= nm_in;
      for (int k = 1; k < NS; k++) begin
        st_r[k] <= sq_step(st_r[k-1], qmn_pkg::STW'(1) << (qmn_pkg::RADW - 2 - 2 * k));
        nm_r[k] <= nm_r[k-1];
      end
    end
  end

  assign v_out    = v_r[NS-1];
  assign root_out = st_r[NS-1].res[qmn_pkg::ROOTW-1:0];
  assign nm_out   = nm_r[NS-1];

endmodule

// ===== rtl/core/qmn_div.sv =====
// Four-lane pipelined restoring divider, one quotient bit per register stage.
// Depends on qmn_pkg.
module qmn_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              v_in,
  input  logic [qmn_pkg::ROOTW-1:0]         n_in,
  input  qmn_pkg::norm_t                    nm_in,
  output logic                              v_out,
  output logic [3:0][qmn_pkg::QBITS-1:0]    quo_out,
  output logic [3:0]                        neg_out,
  output logic                              degen_out
);

  typedef struct packed {
    logic [3:0][qmn_pkg::REMW-1:0]  rem;
    logic [3:0][qmn_pkg::QBITS-1:0] nlo;
    logic [3:0][qmn_pkg::QBITS-1:0] quo;
    logic [qmn_pkg::ROOTW-1:0]      n;
    logic [3:0]                     neg;
    logic                           degen;
  } dst_t;

  localparam int NS = qmn_pkg::QBITS + 1;

  logic [NS-1:0]              v_r;
  dst_t                       st_r [NS];
  dst_t                       st_in;
  logic [qmn_pkg::ROOTW-1:0]  nn;
  logic [qmn_pkg::NUMW-1:0]   num;

  function automatic dst_t div_step(dst_t s);
    dst_t o;
    logic [qmn_pkg::REMW-1:0] t;
    o = s;
    for (int i = 0; i < 4; i++) begin
      t = {s.rem[i][qmn_pkg::REMW-2:0], s.nlo[i][qmn_pkg::QBITS-1]};
      o.nlo[i] = s.nlo[i] << 1;
      if (t >= qmn_pkg::REMW'(s.n)) begin
        o.rem[i] = t - qmn_pkg::REMW'(s.n);
        o.quo[i] = {s.quo[i][qmn_pkg::QBITS-2:0], 1'b1};
      end else begin
        o.rem[i] = t;
        o.quo[i] = {s.quo[i][qmn_pkg::QBITS-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  always_comb begin
    nn = (n_in == '0) ? qmn_pkg::ROOTW'(1) : n_in;
    st_in.n     = nn;
    st_in.neg   = nm_in.neg;
    st_in.degen = nm_in.degen;
    st_in.quo   = '0;
    num = '0;
    for (int i = 0; i < 4; i++) begin
      num = (qmn_pkg::NUMW'(nm_in.q[i]) << qmn_pkg::FRAC_BITS) + qmn_pkg::NUMW'(nn >> 1);
      st_in.rem[i] = qmn_pkg::REMW'(num[qmn_pkg::NUMW-1:qmn_pkg::QBITS]);
      st_in.nlo[i] = num[qmn_pkg::QBITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= st_in;
      for (int k = 1; k < NS; k++) begin
        st_r[k] <= div_step(st_r[k-1]);
      end
    end
  end

  assign v_out     = v_r[NS-1];
  assign quo_out   = st_r[NS-1].quo;
  assign neg_out   = st_r[NS-1].neg;
  assign degen_out = st_r[NS-1].degen;

endmodule

// ===== rtl/core/quaternion_multiply_normalize_top.sv =====
// Top level of the quaternion multiply and normalize block with output skid buffer.
// Depends on qmn_pkg, qmn_product, qmn_scale, qmn_sqrt, qmn_div and the assert header.
//
// Channel   Direction  Payload
// in_       slave      tdata: a_w a_x a_y a_z b_w b_x b_y b_z, 16 bits each
// out_      master     tdata: r_w r_x r_y r_z, 16 bits each; tuser: degenerate
// cfg_      write      norm_floor, 15 bits
//
// One item is accepted per cycle while in_tready is high; out_tvalid is registered.
// The depth is dominated by the 31-stage square root and the 16-stage divider.
// Reset is synchronous and active low; it clears valid bits and sets norm_floor to 1.
// When the output stalls, a skid register takes one more item, then in_tready falls.
`include "quaternion_multiply_normalize_top_assert.svh"
module quaternion_multiply_normalize_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z from bit 0 up
  input  logic [qmn_pkg::IN_W-1:0]      in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // r_w, r_x, r_y, r_z from bit 0 up
  output logic [qmn_pkg::OUT_W-1:0]     out_tdata,
  // degenerate
  output logic                          out_tuser,
  input  logic                          cfg_wr_en,
  input  logic [qmn_pkg::FLOORW-1:0]    cfg_wr_data
);

  logic                               en;
  logic                               out_v_r;
  logic                               skid_v_r;
  logic [qmn_pkg::OUT_W:0]            out_d_r;
  logic [qmn_pkg::OUT_W:0]            skid_d_r;
  logic [qmn_pkg::OUT_W:0]            res;
  logic [qmn_pkg::F2W-1:0]            f2_r;
  logic                               pv;
  logic [3:0][qmn_pkg::PW-1:0]        p;
  logic [qmn_pkg::NAW-1:0]            na;
  logic [qmn_pkg::NAW-1:0]            nb;
  logic                               sv;
  logic [qmn_pkg::RADW-1:0]           sq;
  qmn_pkg::norm_t                     snm;
  logic                               rv;
  logic [qmn_pkg::ROOTW-1:0]          root;
  qmn_pkg::norm_t                     rnm;
  logic                               dv;
  logic [3:0][qmn_pkg::QBITS-1:0]     quo;
  logic [3:0]                         neg;
  logic                               degen;
  logic [qmn_pkg::QBITS-1:0]          lim;

  assign en        = !skid_v_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_r <= qmn_pkg::F2W'(1);
    end else if (cfg_wr_en) begin
      f2_r <= cfg_wr_data * cfg_wr_data;
    end
  end

  qmn_product u_product (
    .clk, .rst_n, .en,
    .v_in(in_tvalid && in_tready), .d_in(in_tdata),
    .v_out(pv), .p_out(p), .na_out(na), .nb_out(nb)
  );

  qmn_scale u_scale (
    .clk, .rst_n, .en,
    .v_in(pv), .p_in(p), .na_in(na), .nb_in(nb), .f2(f2_r),
    .v_out(sv), .sq_out(sq), .nm_out(snm)
  );

  qmn_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .v_in(sv), .sq_in(sq), .nm_in(snm),
    .v_out(rv), .root_out(root), .nm_out(rnm)
  );

  qmn_div u_div (
    .clk, .rst_n, .en,
    .v_in(rv), .n_in(root), .nm_in(rnm),
    .v_out(dv), .quo_out(quo), .neg_out(neg), .degen_out(degen)
  );

  always_comb begin
    res = '0;
    lim = '0;
    if (degen) begin
      res[qmn_pkg::DW-1:0]    = qmn_pkg::ONE;
      res[qmn_pkg::OUT_W]     = 1'b1;
    end else begin
      for (int i = 0; i < 4; i++) begin
        lim = (quo[i] > qmn_pkg::QBITS'(qmn_pkg::ONE)) ? qmn_pkg::QBITS'(qmn_pkg::ONE) : quo[i];
        res[qmn_pkg::DW*i +: qmn_pkg::DW] = neg[i] ? qmn_pkg::DW'(-qmn_pkg::DW'(lim))
                                                   : qmn_pkg::DW'(lim);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        skid_v_r <= 1'b0;
      end
    end else if (dv) begin
      if (!out_v_r || out_tready) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_tready) begin
        out_d_r <= skid_d_r;
      end
    end else if (dv) begin
      if (!out_v_r || out_tready) begin
        out_d_r <= res;
      end else begin
        skid_d_r <= res;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r[qmn_pkg::OUT_W-1:0];
  assign out_tuser  = out_d_r[qmn_pkg::OUT_W];

  `QMN_ASSERT(a_skid_needs_out, clk, rst_n, skid_v_r |-> out_v_r)
  `QMN_ASSERT(a_degen_identity, clk, rst_n, (out_v_r && out_tuser) |-> (out_tdata[qmn_pkg::DW-1:0] == qmn_pkg::ONE && out_tdata[qmn_pkg::OUT_W-1:qmn_pkg::DW] == '0))
  `QMN_NEVER(a_w_range, clk, rst_n, out_v_r && ($signed(out_tdata[qmn_pkg::DW-1:0]) > $signed(qmn_pkg::ONE) || $signed(out_tdata[qmn_pkg::DW-1:0]) < -$signed(qmn_pkg::ONE)))
  `QMN_ASSERT(a_stall_blocks_in, clk, rst_n, (skid_v_r && !out_tready) |=> !in_tready)

endmodule
